### sv/mtp_pkg.sv
// Shared types, codes and constants of the multiclass thread picker.
package mtp_pkg;

   localparam int SLOTS_DEF  = 64;
   localparam int LEVELS_DEF = 32;
   localparam int CPUS_DEF   = 8;

   localparam int KEY_W  = 48;
   localparam int LVL_W  = 6;
   localparam int AGE_W  = 32;
   localparam int RANK_W = KEY_W + LVL_W + AGE_W;

   // batch charge: (ran << 10) / weight
   localparam int WEIGHT_SHIFT = 10;
   localparam int DIVIDEND_W   = 40 + WEIGHT_SHIFT;
   localparam int DIVISOR_W    = 20;
   localparam logic [DIVISOR_W-1:0] WEIGHT_UNIT = 20'd1024;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SLICE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SLICE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INF_SLICE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_STEP = 2'd3;

   localparam logic [31:0] BASE_SLICE_RST = 32'd4000000;
   localparam logic [31:0] MAX_SLICE_RST  = 32'd40000000;
   localparam logic [31:0] INF_SLICE_RST  = 32'd8000000;
   localparam logic [31:0] SLICE_STEP_RST = 32'd500000;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PICK    = 2'd1,
      OP_CHARGE  = 2'd2,
      OP_REMOVE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_RT    = 2'd0,
      KIND_INF   = 2'd1,
      KIND_INTER = 2'd2,
      KIND_BATCH = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_CONFLICT = 2'd2
   } status_type;

   typedef struct packed {
      op_type      operation;
      logic [5:0]  slot;
      kind_type    sched_kind;
      logic [5:0]  prio_level;
      logic [47:0] abs_deadline;
      logic [39:0] period_budget;
      logic [39:0] budget_remaining;
      logic [19:0] fair_weight;
      logic [7:0]  cpu_mask;
      logic [47:0] virtual_runtime;
      logic [2:0]  cpu_id;
      logic [39:0] ran_ns;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  chosen_slot;
      logic [31:0] slice_out_ns;
      logic        overrun_pick;
      logic [47:0] vruntime_out;
      logic [39:0] budget_left_out;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  level;
      logic [47:0] deadline;
      logic [39:0] budget;
      logic [39:0] budget_left;
      logic [19:0] weight;
      logic [7:0]  cpus;
      logic [47:0] vruntime;
      logic [31:0] order;
   } slot_rec_type;

endpackage

### sv/mtp_cell.sv
// One slot cell of the rotating slot ring: ready flag and slot record.
module mtp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  logic                  ready_in,
   input  mtp_pkg::slot_rec_type rec_in,
   output logic                  ready_out,
   output mtp_pkg::slot_rec_type rec_out
);

   logic                  ready_ff;
   mtp_pkg::slot_rec_type rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else if (shift_en) begin
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         rec_ff <= rec_in;
      end
   end

   assign ready_out = ready_ff;
   assign rec_out   = rec_ff;

endmodule

### sv/mtp_div.sv
// Restoring divider, one quotient bit per cycle, for the batch charge.
module mtp_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [mtp_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [mtp_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             busy,
   output logic [mtp_pkg::DIVIDEND_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(mtp_pkg::DIVIDEND_W + 1);

   logic [mtp_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [mtp_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [mtp_pkg::DIVISOR_W-1:0]  div_ff;
   logic [CNT_W-1:0]               cnt_ff;
   logic                           busy_ff;
   logic [mtp_pkg::DIVISOR_W:0]    rem_sh;
   logic                           fits;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[mtp_pkg::DIVIDEND_W-1]};
      fits   = rem_sh >= {1'b0, div_ff};
      rem_in = fits ? mtp_pkg::DIVISOR_W'(rem_sh - {1'b0, div_ff})
                    : rem_sh[mtp_pkg::DIVISOR_W-1:0];
      quo_in = {quo_ff[mtp_pkg::DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(mtp_pkg::DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

### sv/multiclass_thread_picker.sv
// Multiclass thread picker top level: slot ring, scan, update and response.
// Every operation makes one full turn of the slot ring to scan, takes a decision
// step, makes a second full turn to apply the change, and then forms the response.
// The next item is accepted only once the response has been raised. A charge to
// a batch slot adds a bit-serial divide of the weighted run time between the
// decision and the update turn. The slot ring rotates one cell per cycle past a
// single head port while it scans or updates. One item is in flight at a time;
// the response register lets the next item enter while a result waits.
// Configuration writes take effect at once: a pick's slice is formed from the
// registers as they stand when its response is formed.
module multiclass_thread_picker #(
   parameter int SLOTS  = mtp_pkg::SLOTS_DEF,
   parameter int LEVELS = mtp_pkg::LEVELS_DEF,
   parameter int CPUS   = mtp_pkg::CPUS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mtp_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mtp_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [mtp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mtp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [5:0] LVL_MAX = 6'(LEVELS - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_UPDATE, S_FIN
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [31:0] base_slice_ff, max_slice_ff, inf_slice_ff, slice_step_ff;

   // ring
   logic                  cell_ready [SLOTS];
   mtp_pkg::slot_rec_type cell_rec   [SLOTS];
   logic                  link_ready [SLOTS];
   mtp_pkg::slot_rec_type link_rec   [SLOTS];
   logic                  shift_en;
   logic                  head_ready, head_ready_new;
   mtp_pkg::slot_rec_type head_rec, head_rec_new;

   // operation registers
   mtp_pkg::req_type      req_ff, req_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [31:0]           order_ff, order_in;
   logic [mtp_pkg::RANK_W-1:0] best_rank_ff [4];
   logic [mtp_pkg::RANK_W-1:0] best_rank_in [4];
   logic [IDX_W-1:0]      best_idx_ff [4];
   logic [IDX_W-1:0]      best_idx_in [4];
   logic [3:0]            best_found_ff, best_found_in;
   logic                  inf_ok_ff, inf_ok_in;
   logic                  tgt_ready_ff, tgt_ready_in;
   mtp_pkg::slot_rec_type tgt_rec_ff, tgt_rec_in;
   mtp_pkg::slot_rec_type cap_ff, cap_in;
   mtp_pkg::status_type   status_ff, status_in;
   logic [IDX_W-1:0]      chosen_ff, chosen_in;
   logic                  overrun_ff, overrun_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mtp_pkg::rsp_type      rsp_ff, rsp_in;

   // combinational helpers
   logic                  head_last, cpu_ok, in_range, match_slot, match_pick;
   logic                  elig, better, upd_hit, div_start, div_busy;
   logic [47:0]           key;
   logic [31:0]           age;
   logic [mtp_pkg::RANK_W-1:0] rank;
   logic [mtp_pkg::DIVIDEND_W-1:0] quotient;
   logic [mtp_pkg::DIVISOR_W-1:0]  weight_eff;
   logic [50:0]           vr_sum;
   logic [47:0]           vr_new;
   logic [39:0]           bl_new;
   mtp_pkg::slot_rec_type upd_rec;
   logic                  upd_ready;
   logic [37:0]           step_prod;
   logic [38:0]           inter_sum;
   logic [31:0]           slice;

   // ------------------------------------------------------------------ ring
   assign head_ready = cell_ready[0];
   assign head_rec   = cell_rec[0];
   assign shift_en   = (state_ff == S_SCAN) || (state_ff == S_UPDATE);

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == SLOTS - 1) begin : g_tail
         assign link_ready[i] = head_ready_new;
         assign link_rec[i]   = head_rec_new;
      end else begin : g_mid
         assign link_ready[i] = cell_ready[i+1];
         assign link_rec[i]   = cell_rec[i+1];
      end
      mtp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .ready_in  (link_ready[i]),
         .rec_in    (link_rec[i]),
         .ready_out (cell_ready[i]),
         .rec_out   (cell_rec[i])
      );
   end

   // -------------------------------------------------------------- divider
   assign weight_eff = (tgt_rec_ff.weight == '0) ? mtp_pkg::WEIGHT_UNIT : tgt_rec_ff.weight;

   mtp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({req_ff.ran_ns, mtp_pkg::WEIGHT_SHIFT'(0)}),
      .divisor  (weight_eff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // ---------------------------------------------------------- head logic
   always_comb begin
      head_last  = head_ff == IDX_W'(SLOTS - 1);
      cpu_ok     = 32'(req_ff.cpu_id) < 32'(CPUS);
      in_range   = 32'(req_ff.slot) < 32'(SLOTS);
      match_slot = 32'(head_ff) == 32'(req_ff.slot);
      match_pick = head_ff == chosen_ff;

      elig = head_ready && cpu_ok && head_rec.cpus[req_ff.cpu_id];
      case (head_rec.kind)
         mtp_pkg::KIND_RT, mtp_pkg::KIND_INF: key = head_rec.deadline;
         mtp_pkg::KIND_BATCH:                 key = head_rec.vruntime;
         default:                             key = '0;
      endcase
      age    = order_ff - head_rec.order;
      // smaller rank wins: key, then level, then older enqueue
      rank   = {key, head_rec.level, ~age};
      better = !best_found_ff[head_rec.kind] || (rank < best_rank_ff[head_rec.kind]);

      // charge arithmetic on the captured target
      vr_sum = {3'b0, tgt_rec_ff.vruntime} + {1'b0, quotient};
      if (tgt_rec_ff.kind == mtp_pkg::KIND_BATCH) begin
         vr_new = (vr_sum[50:48] != 3'b0) ? '1 : vr_sum[47:0];
      end else begin
         vr_new = tgt_rec_ff.vruntime;
      end
      if (tgt_rec_ff.kind == mtp_pkg::KIND_INF) begin
         bl_new = (req_ff.ran_ns >= tgt_rec_ff.budget_left) ? '0
                : tgt_rec_ff.budget_left - req_ff.ran_ns;
      end else begin
         bl_new = tgt_rec_ff.budget_left;
      end

      upd_rec   = head_rec;
      upd_ready = head_ready;
      case (req_ff.operation)
         mtp_pkg::OP_ENQUEUE: begin
            upd_rec.kind        = req_ff.sched_kind;
            upd_rec.level       = (32'(req_ff.prio_level) > 32'(LEVELS - 1))
                                ? LVL_MAX : req_ff.prio_level;
            upd_rec.deadline    = req_ff.abs_deadline;
            upd_rec.budget      = req_ff.period_budget;
            upd_rec.budget_left = req_ff.budget_remaining;
            upd_rec.weight      = req_ff.fair_weight;
            upd_rec.cpus        = req_ff.cpu_mask;
            upd_rec.vruntime    = req_ff.virtual_runtime;
            upd_rec.order       = order_ff;
            upd_ready           = 1'b1;
         end
         mtp_pkg::OP_CHARGE: begin
            upd_rec.vruntime    = vr_new;
            upd_rec.budget_left = bl_new;
         end
         default: begin
            upd_ready = 1'b0;
         end
      endcase

      upd_hit = (state_ff == S_UPDATE) && (status_ff == mtp_pkg::ST_OK)
             && ((req_ff.operation == mtp_pkg::OP_PICK) ? match_pick : match_slot);
      head_ready_new = upd_hit ? upd_ready : head_ready;
      head_rec_new   = upd_hit ? upd_rec : head_rec;
   end

   // ------------------------------------------------------------ slice
   always_comb begin
      step_prod = 38'(cap_ff.level) * 38'(slice_step_ff);
      inter_sum = 39'(base_slice_ff) + 39'(step_prod);
      case (cap_ff.kind)
         mtp_pkg::KIND_RT: begin
            if (cap_ff.budget == '0) slice = max_slice_ff;
            else slice = (cap_ff.budget[39:32] != 8'b0) ? '1 : cap_ff.budget[31:0];
         end
         mtp_pkg::KIND_INF: begin
            if (cap_ff.budget == '0) slice = inf_slice_ff;
            else slice = (cap_ff.budget < {8'b0, max_slice_ff})
                       ? cap_ff.budget[31:0] : max_slice_ff;
         end
         mtp_pkg::KIND_INTER: begin
            slice = (inter_sum[38:32] != 7'b0) ? '1 : inter_sum[31:0];
         end
         default: slice = max_slice_ff;
      endcase
   end

   // ------------------------------------------------------- control path
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      order_in      = order_ff;
      best_rank_in  = best_rank_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      inf_ok_in     = inf_ok_ff;
      tgt_ready_in  = tgt_ready_ff;
      tgt_rec_in    = tgt_rec_ff;
      cap_in        = cap_ff;
      status_in     = status_ff;
      chosen_in     = chosen_ff;
      overrun_in    = overrun_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               head_in       = '0;
               best_found_in = '0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (req_ff.operation == mtp_pkg::OP_PICK && elig && better) begin
               best_found_in[head_rec.kind] = 1'b1;
               best_rank_in[head_rec.kind]  = rank;
               best_idx_in[head_rec.kind]   = head_ff;
               if (head_rec.kind == mtp_pkg::KIND_INF) begin
                  inf_ok_in = (head_rec.budget_left != '0) || (head_rec.budget == '0);
               end
            end
            if (match_slot) begin
               tgt_ready_in = head_ready;
               tgt_rec_in   = head_rec;
            end
            head_in = head_last ? '0 : head_ff + 1'b1;
            if (head_last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            overrun_in = 1'b0;
            chosen_in  = '0;
            status_in  = mtp_pkg::ST_OK;
            if (req_ff.operation == mtp_pkg::OP_PICK) begin
               if (best_found_ff[mtp_pkg::KIND_RT]) begin
                  chosen_in = best_idx_ff[mtp_pkg::KIND_RT];
               end else if (best_found_ff[mtp_pkg::KIND_INF] && inf_ok_ff) begin
                  chosen_in = best_idx_ff[mtp_pkg::KIND_INF];
               end else if (best_found_ff[mtp_pkg::KIND_INTER]) begin
                  chosen_in = best_idx_ff[mtp_pkg::KIND_INTER];
               end else if (best_found_ff[mtp_pkg::KIND_BATCH]) begin
                  chosen_in = best_idx_ff[mtp_pkg::KIND_BATCH];
               end else if (best_found_ff[mtp_pkg::KIND_INF]) begin
                  chosen_in  = best_idx_ff[mtp_pkg::KIND_INF];
                  overrun_in = 1'b1;
               end else begin
                  status_in = mtp_pkg::ST_EMPTY;
               end
            end else if (!in_range) begin
               status_in = mtp_pkg::ST_CONFLICT;
            end else if (req_ff.operation == mtp_pkg::OP_ENQUEUE && tgt_ready_ff) begin
               status_in = mtp_pkg::ST_CONFLICT;
            end else if (req_ff.operation == mtp_pkg::OP_REMOVE && !tgt_ready_ff) begin
               status_in = mtp_pkg::ST_CONFLICT;
            end
            div_start = (req_ff.operation == mtp_pkg::OP_CHARGE) && in_range
                     && (tgt_rec_ff.kind == mtp_pkg::KIND_BATCH);
            state_in  = div_start ? S_DIV : S_UPDATE;
         end
         S_DIV: begin
            if (!div_busy) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (upd_hit) begin
               cap_in = upd_rec;
               if (req_ff.operation == mtp_pkg::OP_ENQUEUE) order_in = order_ff + 1'b1;
            end
            head_in = head_last ? '0 : head_ff + 1'b1;
            if (head_last) state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status       = status_ff;
               rsp_in.chosen_slot  = (status_ff == mtp_pkg::ST_EMPTY) ? 6'b0
                                   : (req_ff.operation == mtp_pkg::OP_PICK) ? 6'(chosen_ff)
                                   : req_ff.slot;
               rsp_in.slice_out_ns = '0;
               rsp_in.overrun_pick = 1'b0;
               rsp_in.vruntime_out    = '0;
               rsp_in.budget_left_out = '0;
               if (status_ff == mtp_pkg::ST_OK) begin
                  rsp_in.vruntime_out    = cap_ff.vruntime;
                  rsp_in.budget_left_out = cap_ff.budget_left;
                  if (req_ff.operation == mtp_pkg::OP_PICK) begin
                     rsp_in.slice_out_ns = slice;
                     rsp_in.overrun_pick = overrun_ff;
                  end
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         order_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= '0;
         base_slice_ff <= mtp_pkg::BASE_SLICE_RST;
         max_slice_ff  <= mtp_pkg::MAX_SLICE_RST;
         inf_slice_ff  <= mtp_pkg::INF_SLICE_RST;
         slice_step_ff <= mtp_pkg::SLICE_STEP_RST;
      end else begin
         state_ff      <= state_in;
         order_ff      <= order_in;
         rsp_valid_ff  <= rsp_valid_in;
         best_found_ff <= best_found_in;
         if (csr_we) begin
            case (csr_index)
               mtp_pkg::CSR_BASE_SLICE: base_slice_ff <= csr_wdata;
               mtp_pkg::CSR_MAX_SLICE:  max_slice_ff  <= csr_wdata;
               mtp_pkg::CSR_INF_SLICE:  inf_slice_ff  <= csr_wdata;
               mtp_pkg::CSR_SLICE_STEP: slice_step_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      req_ff       <= req_in;
      head_ff      <= head_in;
      best_rank_ff <= best_rank_in;
      best_idx_ff  <= best_idx_in;
      inf_ok_ff    <= inf_ok_in;
      tgt_ready_ff <= tgt_ready_in;
      tgt_rec_ff   <= tgt_rec_in;
      cap_ff       <= cap_in;
      status_ff    <= status_in;
      chosen_ff    <= chosen_in;
      overrun_ff   <= overrun_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ----------------------------------------------------------- checks
   a_decide_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> head_ff == '0)
      else $error("ring not aligned at decision");

   a_scan_keeps_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |=> $stable(order_ff))
      else $error("enqueue order moved during scan");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("response raised outside finish");

   a_overrun_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overrun_pick |-> rsp_ff.status == mtp_pkg::ST_OK)
      else $error("overrun flagged on failed pick");

   a_div_only_charge: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == S_DIV)
      else $error("divider busy outside divide state");

endmodule

### tb/testbench.sv
// Self-checking testbench for the multiclass thread picker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 64;
   localparam int NLVL  = 32;
   localparam int NCPU  = 8;

   // Scheduler shadow: slot table, registers and the queue of expected responses.
   class sched_scoreboard;
      bit                    rdy[NSLOT];
      bit                    written[NSLOT];
      mtp_pkg::slot_rec_type tbl[NSLOT];
      logic [31:0]           order_cnt;
      logic [31:0]           regs[4];
      mtp_pkg::rsp_type      pending[$];
      int                    errors;
      int                    n_checked;

      function void clear();
         foreach (rdy[i]) begin
            rdy[i] = 1'b0;
            written[i] = 1'b0;
            tbl[i] = '0;
         end
         order_cnt = '0;
         regs[mtp_pkg::CSR_BASE_SLICE] = mtp_pkg::BASE_SLICE_RST;
         regs[mtp_pkg::CSR_MAX_SLICE]  = mtp_pkg::MAX_SLICE_RST;
         regs[mtp_pkg::CSR_INF_SLICE]  = mtp_pkg::INF_SLICE_RST;
         regs[mtp_pkg::CSR_SLICE_STEP] = mtp_pkg::SLICE_STEP_RST;
         errors = 0;
         n_checked = 0;
      endfunction

      function logic [47:0] rank_key(int s);
         if (tbl[s].kind == mtp_pkg::KIND_RT || tbl[s].kind == mtp_pkg::KIND_INF)
            return tbl[s].deadline;
         if (tbl[s].kind == mtp_pkg::KIND_BATCH) return tbl[s].vruntime;
         return '0;
      endfunction

      function bit wins(int a, int b);
         logic [31:0] age_a, age_b;
         age_a = order_cnt - tbl[a].order;
         age_b = order_cnt - tbl[b].order;
         if (rank_key(a) != rank_key(b)) return rank_key(a) < rank_key(b);
         if (tbl[a].level != tbl[b].level) return tbl[a].level < tbl[b].level;
         return age_a > age_b;
      endfunction

      function int best_in(mtp_pkg::kind_type k, int cpu);
         int best;
         best = -1;
         for (int s = 0; s < NSLOT; s++)
            if (rdy[s] && tbl[s].kind == k && tbl[s].cpus[cpu])
               if (best < 0 || wins(s, best)) best = s;
         return best;
      endfunction

      function logic [31:0] clip32(logic [63:0] v);
         return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      function logic [31:0] grant_slice(int s);
         logic [39:0] b;
         b = tbl[s].budget;
         case (tbl[s].kind)
            mtp_pkg::KIND_RT:
               return (b != 0) ? clip32(64'(b)) : regs[mtp_pkg::CSR_MAX_SLICE];
            mtp_pkg::KIND_INF: begin
               if (b == 0) return regs[mtp_pkg::CSR_INF_SLICE];
               return (b < 40'(regs[mtp_pkg::CSR_MAX_SLICE])) ? b[31:0]
                      : regs[mtp_pkg::CSR_MAX_SLICE];
            end
            mtp_pkg::KIND_INTER:
               return clip32(64'(regs[mtp_pkg::CSR_BASE_SLICE]) +
                             64'(tbl[s].level) * 64'(regs[mtp_pkg::CSR_SLICE_STEP]));
            default:  return regs[mtp_pkg::CSR_MAX_SLICE];
         endcase
      endfunction

      function void note_request(mtp_pkg::req_type r);
         mtp_pkg::rsp_type e;
         int               s, inf, sl, cpu;
         logic [63:0]      add, v;
         logic [39:0]      ran;
         e = '0;
         sl = int'(r.slot);
         cpu = int'(r.cpu_id);
         if (r.operation == mtp_pkg::OP_PICK) begin
            s = best_in(mtp_pkg::KIND_RT, cpu);
            inf = best_in(mtp_pkg::KIND_INF, cpu);
            if (s < 0 && inf >= 0 &&
                (tbl[inf].budget_left != 0 || tbl[inf].budget == 0)) s = inf;
            if (s < 0) s = best_in(mtp_pkg::KIND_INTER, cpu);
            if (s < 0) s = best_in(mtp_pkg::KIND_BATCH, cpu);
            if (s < 0 && inf >= 0) begin
               s = inf;
               e.overrun_pick = 1'b1;
            end
            if (s < 0) e.status = mtp_pkg::ST_EMPTY;
            else begin
               rdy[s] = 1'b0;
               e.chosen_slot = 6'(s);
               e.slice_out_ns = grant_slice(s);
               e.vruntime_out = tbl[s].vruntime;
               e.budget_left_out = tbl[s].budget_left;
            end
         end else begin
            e.chosen_slot = r.slot;
            if (r.operation == mtp_pkg::OP_ENQUEUE) begin
               if (rdy[sl]) e.status = mtp_pkg::ST_CONFLICT;
               else begin
                  tbl[sl].kind = r.sched_kind;
                  tbl[sl].level = (r.prio_level > NLVL - 1) ? 6'(NLVL - 1) : r.prio_level;
                  tbl[sl].deadline = r.abs_deadline;
                  tbl[sl].budget = r.period_budget;
                  tbl[sl].budget_left = r.budget_remaining;
                  tbl[sl].weight = r.fair_weight;
                  tbl[sl].cpus = r.cpu_mask;
                  tbl[sl].vruntime = r.virtual_runtime;
                  tbl[sl].order = order_cnt;
                  order_cnt++;
                  rdy[sl] = 1'b1;
                  written[sl] = 1'b1;
               end
            end else if (r.operation == mtp_pkg::OP_CHARGE) begin
               ran = r.ran_ns;
               if (tbl[sl].kind == mtp_pkg::KIND_BATCH) begin
                  add = (64'(ran) * 64'd1024) /
                        ((tbl[sl].weight != 0) ? 64'(tbl[sl].weight) : 64'd1024);
                  v = 64'(tbl[sl].vruntime) + add;
                  tbl[sl].vruntime = (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
               end
               if (tbl[sl].kind == mtp_pkg::KIND_INF && tbl[sl].budget_left != 0)
                  tbl[sl].budget_left = (ran >= tbl[sl].budget_left) ? 40'd0 :
                                        tbl[sl].budget_left - ran;
            end else begin
               if (rdy[sl]) rdy[sl] = 1'b0;
               else e.status = mtp_pkg::ST_CONFLICT;
            end
            if (e.status == mtp_pkg::ST_OK) begin
               e.vruntime_out = tbl[sl].vruntime;
               e.budget_left_out = tbl[sl].budget_left;
            end
         end
         pending.push_back(e);
      endfunction

      function void check_response(mtp_pkg::rsp_type got);
         mtp_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $realtime, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (got.status != e.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, e.status, got.status);
            errors++;
         end
         if (got.chosen_slot != e.chosen_slot) begin
            $display("%0t: chosen_slot exp %0d got %0d", $realtime, e.chosen_slot,
                     got.chosen_slot);
            errors++;
         end
         if (got.slice_out_ns != e.slice_out_ns) begin
            $display("%0t: slice_out_ns exp %0d got %0d", $realtime, e.slice_out_ns,
                     got.slice_out_ns);
            errors++;
         end
         if (got.overrun_pick != e.overrun_pick) begin
            $display("%0t: overrun_pick exp %0d got %0d", $realtime, e.overrun_pick,
                     got.overrun_pick);
            errors++;
         end
         if (got.vruntime_out != e.vruntime_out) begin
            $display("%0t: vruntime_out exp %0h got %0h", $realtime, e.vruntime_out,
                     got.vruntime_out);
            errors++;
         end
         if (got.budget_left_out != e.budget_left_out) begin
            $display("%0t: budget_left_out exp %0h got %0h", $realtime, e.budget_left_out,
                     got.budget_left_out);
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   mtp_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   mtp_pkg::rsp_type               rsp_data;
   logic                           csr_we;
   logic [mtp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mtp_pkg::CSR_DATA_W-1:0] csr_wdata;

   sched_scoreboard sb;
   bit  stall_arm;      // asks the receiver for one long hold-off
   bit  stall_used;
   int  stall_left;     // cycles left in the receiver hold-off
   bit  sink_calm;
   int  n_sent;

   multiclass_thread_picker DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("testbench NOT OK");
      $finish;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // response side: random ready, or always ready while the sink is calm, with one long forced hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         stall_used <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (stall_arm && !stall_used) begin
            stall_used <= 1'b1;
            stall_left <= 600;
            rsp_ready  <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (sink_calm) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // valid stays up after the beat; callers drop it before idling
   task automatic send_beat(mtp_pkg::req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      n_sent++;
   endtask

   task automatic send_gapped(mtp_pkg::req_type r, bit gaps);
      int g;
      g = gaps ? pick_gap() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      send_beat(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // write enable stays up across back-to-back writes; caller drops it
   task automatic write_reg(logic [mtp_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.regs[idx] = val;
   endtask

   function mtp_pkg::req_type rand_fields();
      mtp_pkg::req_type r;
      r.operation        = mtp_pkg::op_type'($urandom_range(0, 3));
      r.slot             = 6'($urandom_range(0, 63));
      r.sched_kind       = mtp_pkg::kind_type'($urandom_range(0, 3));
      r.prio_level       = 6'($urandom_range(0, 63));
      r.abs_deadline     = 48'({$urandom, $urandom});
      r.period_budget    = 40'({$urandom, $urandom});
      r.budget_remaining = 40'({$urandom, $urandom});
      r.fair_weight      = 20'($urandom);
      r.cpu_mask         = 8'($urandom);
      r.virtual_runtime  = 48'({$urandom, $urandom});
      r.cpu_id           = 3'($urandom_range(0, 7));
      r.ran_ns           = 40'({$urandom, $urandom});
      // pull keys into narrow ranges often so ties and ordering are exercised
      if ($urandom_range(0, 2) != 0) begin
         r.abs_deadline    = 48'($urandom_range(0, 7));
         r.virtual_runtime = 48'($urandom_range(0, 7));
         r.prio_level      = ($urandom_range(0, 3) == 0) ? r.prio_level
                                                         : 6'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 2) == 0) r.period_budget = 40'($urandom_range(0, 3) * 10000000);
      if ($urandom_range(0, 2) == 0) r.budget_remaining = 40'($urandom_range(0, 2) * 1000);
      if ($urandom_range(0, 3) == 0) r.fair_weight = 20'($urandom_range(0, 4));
      if ($urandom_range(0, 2) == 0) r.cpu_mask = 8'hFF;
      if ($urandom_range(0, 2) == 0) r.ran_ns = 40'($urandom_range(0, 5000));
      return r;
   endfunction

   // well-formed random item; charge only addresses slots that were enqueued
   function mtp_pkg::req_type legal_item();
      mtp_pkg::req_type r;
      int pct;
      r = rand_fields();
      pct = $urandom_range(0, 99);
      if (pct < 40) r.operation = mtp_pkg::OP_ENQUEUE;
      else if (pct < 70) r.operation = mtp_pkg::OP_PICK;
      else if (pct < 88) r.operation = mtp_pkg::OP_CHARGE;
      else r.operation = mtp_pkg::OP_REMOVE;
      if (r.operation == mtp_pkg::OP_CHARGE && !sb.written[r.slot])
         r.operation = mtp_pkg::OP_ENQUEUE;
      return r;
   endfunction

   task automatic directed();
      mtp_pkg::req_type r;
      r = '0;
      r.operation = mtp_pkg::OP_PICK;
      send_beat(r);                              // empty table
      r.operation = mtp_pkg::OP_REMOVE; r.slot = 6'd63;
      send_beat(r);                              // remove of idle slot
      // one slot per class, extremes of fields
      r = '0; r.operation = mtp_pkg::OP_ENQUEUE; r.slot = 6'd0;
      r.sched_kind = mtp_pkg::KIND_RT;
      r.abs_deadline = '1; r.period_budget = '1; r.cpu_mask = 8'h01; r.prio_level = 6'd63;
      send_beat(r);
      send_beat(r);                              // enqueue of a ready slot
      r.slot = 6'd1; r.sched_kind = mtp_pkg::KIND_INF; r.abs_deadline = '0;
      r.period_budget = 40'd100;
      r.budget_remaining = 40'd50; r.cpu_mask = 8'hFF; r.prio_level = 6'd0;
      send_beat(r);
      r.slot = 6'd2; r.sched_kind = mtp_pkg::KIND_INTER; r.prio_level = 6'd40;
      r.period_budget = '0;
      send_beat(r);
      r.slot = 6'd3; r.sched_kind = mtp_pkg::KIND_BATCH; r.fair_weight = '0;
      r.virtual_runtime = 48'hFFFF_FFFF_FF00;
      send_beat(r);
      r.slot = 6'd4; r.fair_weight = '1; r.virtual_runtime = '0; r.cpu_mask = 8'h80;
      send_beat(r);
      r = '0; r.operation = mtp_pkg::OP_CHARGE; r.slot = 6'd3; r.ran_ns = '1;
      send_beat(r);                              // vruntime saturates
      r.slot = 6'd4; r.ran_ns = 40'd5000;
      send_beat(r);
      r.slot = 6'd1; r.ran_ns = 40'd80;
      send_beat(r);                              // budget runs out
      r.slot = 6'd1;
      send_beat(r);                              // already zero
      r = '0; r.operation = mtp_pkg::OP_PICK; r.cpu_id = 3'd7;
      repeat (5) send_beat(r);                   // drains inter, both batch, overrun inference, then empty
      r.cpu_id = 3'd0;
      repeat (2) send_beat(r);                   // realtime then empty
      r.operation = mtp_pkg::OP_REMOVE; r.slot = 6'd4;
      send_beat(r);
      r = '0; r.operation = mtp_pkg::OP_ENQUEUE; r.slot = 6'd5;
      r.sched_kind = mtp_pkg::KIND_INTER;
      r.cpu_mask = 8'h02; r.prio_level = 6'd5;
      send_beat(r);
      r.operation = mtp_pkg::OP_REMOVE;
      send_beat(r);
   endtask

   task automatic phase(int count, bit gaps);
      mtp_pkg::req_type r;
      for (int i = 0; i < count; i++) begin
         r = ($urandom_range(0, 9) == 0) ? rand_fields() : legal_item();
         if (r.operation == mtp_pkg::OP_CHARGE && !sb.written[r.slot])
            r.operation = mtp_pkg::OP_PICK;
         send_gapped(r, gaps);
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = mtp_pkg::CSR_BASE_SLICE;
      csr_wdata = '0;
      stall_arm = 0;
      sink_calm = 0;
      n_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed();
      drain();
      phase(120, 1);
      drain();
      // extremes of the slice registers
      write_reg(mtp_pkg::CSR_BASE_SLICE, 32'hFFFF_FFFF);
      write_reg(mtp_pkg::CSR_MAX_SLICE, 32'd0);
      write_reg(mtp_pkg::CSR_INF_SLICE, 32'hFFFF_FFFF);
      write_reg(mtp_pkg::CSR_SLICE_STEP, 32'hFFFF_FFFF);
      csr_we <= 1'b0;
      phase(120, 1);
      drain();
      write_reg(mtp_pkg::CSR_BASE_SLICE, 32'd0);
      write_reg(mtp_pkg::CSR_MAX_SLICE, 32'hFFFF_FFFF);
      write_reg(mtp_pkg::CSR_INF_SLICE, 32'd0);
      write_reg(mtp_pkg::CSR_SLICE_STEP, 32'd0);
      csr_we <= 1'b0;
      // long receiver stall while the sender keeps offering
      stall_arm = 1;
      phase(120, 0);
      drain();
      write_reg(mtp_pkg::CSR_BASE_SLICE, $urandom);
      write_reg(mtp_pkg::CSR_MAX_SLICE, $urandom_range(0, 60000000));
      write_reg(mtp_pkg::CSR_INF_SLICE, $urandom);
      write_reg(mtp_pkg::CSR_SLICE_STEP, $urandom_range(0, 2000000));
      csr_we <= 1'b0;
      sink_calm = 1;
      phase(100, 0);
      sink_calm = 0;
      phase(170, 1);
      drain();
      $display("Sent %0d requests over four register settings; %0d responses checked.",
               n_sent, sb.n_checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end
endmodule

### filelist.f
sv/mtp_pkg.sv
sv/mtp_cell.sv
sv/mtp_div.sv
sv/multiclass_thread_picker.sv
tb/testbench.sv
